>>> design/svfr_pkg.sv
package svfr_pkg;

  localparam int unsigned CNT_W   = 16;              // tick and step counters
  localparam int unsigned LVL_W   = 7;               // volume levels
  localparam int unsigned MAG_W   = CNT_W + 1;       // magnitude of a signed count
  localparam int unsigned DIV_W   = CNT_W - 1;       // positive period bits
  localparam int unsigned ITER_W  = $clog2(MAG_W);
  localparam int unsigned DIR_W   = 2;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 7'h7f;
  localparam logic [LVL_W-1:0] LEVEL_MIN = 7'h00;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_PERIOD    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_STEP,
    ST_OUT
  } fade_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_status_t;

endpackage

>>> design/svfr_mod.sv
// Bit-serial restoring remainder: one dividend bit per cycle.
module svfr_mod import svfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output mod_status_t      status
);

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(MAG_W - 1);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [MAG_W-1:0]  dvd;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_next;
  logic              done;

  // Shift the next dividend bit in, subtract the divisor when it fits.
  always_comb begin
    trial = {rem, dvd[MAG_W-1]};
    if (trial >= {1'b0, divisor}) begin
      trial_next = trial - {1'b0, divisor};
    end else begin
      trial_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == LAST_ITER) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[MAG_W-2:0], 1'b0};
      rem <= trial_next[DIV_W-1:0];
    end
  end

  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

>>> design/stereo_volume_fade_ramp.sv
// Stereo volume fade ramp, one channel.
// Path: a start word or idle tick goes from accept to ST_OUT; a tick with
// period zero or less via ST_STEP; with a positive period via ST_MOD, the
// bit-serial 17-bit remainder (one bit a cycle), and ST_STEP on a multiple.
// Throughput: one word at a time; the next is taken once the result is queued.
// Reset (rst, synchronous): counters, levels, fade and configuration registers cleared.
module stereo_volume_fade_ramp import svfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] start_ticks, [31:16] start_steps, [38:32] start_left,
  // [45:39] start_right, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] left_volume, [13:7] right_volume, [14] fading, [15] zero
  output logic [15:0] m_axis_tdata
);

  // configuration registers
  logic [DIR_W-1:0] fade_direction;
  logic [CNT_W-1:0] step_period;

  // fade state
  logic [CNT_W-1:0] ticks_left;
  logic [CNT_W-1:0] steps_left;
  logic [LVL_W-1:0] left_level;
  logic [LVL_W-1:0] right_level;
  logic             fade_on;

  fade_state_t state;
  fade_state_t state_next;

  logic        s_accept;
  logic        out_load;
  logic        mod_start;
  mod_status_t mod_status;

  logic             period_pos;
  logic             dir_down;
  logic             dir_up;
  logic [CNT_W-1:0] ticks_dec;
  logic [MAG_W-1:0] ticks_mag;
  logic [MAG_W-1:0] delta;
  logic [CNT_W-1:0] steps_new;
  logic [MAG_W-1:0] left_sum;
  logic [MAG_W-1:0] right_sum;
  logic             levels_ok;
  logic             steps_past;
  logic             stop;
  logic [LVL_W-1:0] bound;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  assign period_pos = !step_period[CNT_W-1] && (step_period != '0);
  assign dir_down   = (fade_direction == 2'b01);
  assign dir_up     = fade_direction[DIR_W-1];

  // Count the tick down and take its magnitude for the multiple test.
  assign ticks_dec = ticks_left - 1'b1;
  assign ticks_mag = ticks_dec[CNT_W-1] ? (MAG_W'(0) - {1'b1, ticks_dec})
                                        : {1'b0, ticks_dec};

  assign mod_start = s_accept && (s_axis_tuser == FUNC_TICK) && fade_on && period_pos;

  svfr_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (ticks_mag),
    .divisor  (step_period[DIV_W-1:0]),
    .status   (mod_status)
  );

  // Signed move of the step count and the levels for one step.
  always_comb begin
    if (period_pos) begin
      delta = dir_down ? {MAG_W{1'b1}} : MAG_W'(1);
    end else if (dir_down) begin
      delta = {step_period[CNT_W-1], step_period};
    end else begin
      delta = MAG_W'(0) - {step_period[CNT_W-1], step_period};
    end
  end

  assign steps_new  = steps_left + delta[CNT_W-1:0];
  assign left_sum   = {{(MAG_W-LVL_W){1'b0}}, left_level} + delta;
  assign right_sum  = {{(MAG_W-LVL_W){1'b0}}, right_level} + delta;
  assign levels_ok  = !left_sum[MAG_W-1] && (left_sum[MAG_W-2:LVL_W] == '0) &&
                      !right_sum[MAG_W-1] && (right_sum[MAG_W-2:LVL_W] == '0);
  assign steps_past = dir_down ? steps_new[CNT_W-1]
                               : (!steps_new[CNT_W-1] && (steps_new != '0));
  assign stop       = steps_past || !levels_ok;
  assign bound      = dir_down ? LEVEL_MIN : LEVEL_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = mod_start ? ST_MOD : ((s_axis_tuser == FUNC_TICK) && fade_on)
                                            ? ST_STEP : ST_OUT;
        end
      end
      ST_MOD: begin
        if (mod_status.done) begin
          state_next = mod_status.rem_zero ? ST_STEP : ST_OUT;
        end
      end
      ST_STEP: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_direction <= '0;
      step_period    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: fade_direction <= cfg_data[DIR_W-1:0];
        CFG_PERIOD:    step_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // fade state: load on start, count on tick, step when due
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_left  <= '0;
      steps_left  <= '0;
      left_level  <= '0;
      right_level <= '0;
      fade_on     <= 1'b0;
    end else if (s_accept) begin
      if (s_axis_tuser == FUNC_START) begin
        ticks_left  <= s_axis_tdata[15:0];
        steps_left  <= s_axis_tdata[31:16];
        left_level  <= s_axis_tdata[38:32];
        right_level <= s_axis_tdata[45:39];
        fade_on     <= 1'b1;
      end else if (fade_on) begin
        ticks_left <= ticks_dec;
      end
    end else if (state == ST_STEP) begin
      if (dir_down || dir_up) begin
        steps_left <= steps_new;
        if (stop) begin
          left_level  <= bound;
          right_level <= bound;
        end else begin
          left_level  <= left_sum[LVL_W-1:0];
          right_level <= right_sum[LVL_W-1:0];
        end
        if (stop || (ticks_left == '0) || (steps_new == '0)) begin
          fade_on <= 1'b0;
        end
      end else if ((ticks_left == '0) || (steps_left == '0)) begin
        // hold the volume, still end on an empty counter
        fade_on <= 1'b0;
      end
    end
  end

  // output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, fade_on, right_level, left_level};
    end
  end

  // remainder unit runs only on a positive period
  a_mod_period: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> period_pos)
    else $error("remainder running without a positive period");

  // remainder result only while waiting for it
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_status.done |-> (state == ST_MOD))
    else $error("remainder finished outside its wait state");

  // a tick while inactive changes nothing
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_axis_tuser == FUNC_TICK) && !fade_on) |=>
      ($stable(left_level) && $stable(ticks_left) && !fade_on))
    else $error("inactive tick changed the fade state");

  // a result is queued only when the output slot is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !out_load)
    else $error("result overwritten before taken");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import svfr_pkg::*;

  // One result word as the checker sees it.
  typedef struct packed {
    logic       fading;
    logic [6:0] right;
    logic [6:0] left;
  } vol_word_t;

  // One row of the directed table: register setting, input word and,
  // where the answer is obvious, the result to expect.
  typedef struct packed {
    int   dir;
    int   period;
    logic func;
    int   ticks;
    int   steps;
    int   left;
    int   right;
    logic typed;
    int   exp_left;
    int   exp_right;
    logic exp_fading;
  } fade_row_t;

  localparam logic TYPED = 1'b1;   // row carries its own expected result
  localparam logic PRED  = 1'b0;   // row is checked against the predictor

  localparam int N_PHASES    = 10;
  localparam int PHASE_WORDS = 120;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [15:0] start_ticks, [31:16] start_steps, [38:32] start_left,
  // [45:39] start_right, [47:46] zero
  logic [47:0] s_axis_tdata;
  // [0] func
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [6:0] left_volume, [13:7] right_volume, [14] fading, [15] zero
  logic [15:0] m_axis_tdata;

  stereo_volume_fade_ramp uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor copy of the fade state and the two registers.
  logic signed [15:0] tick_count;
  logic signed [15:0] step_count;
  int                 vol_left;
  int                 vol_right;
  logic               ramp_active;
  logic signed [1:0]  dir_setting;
  logic signed [15:0] period_setting;

  vol_word_t fade_expect_q[$];

  int  fail_count      = 0;
  int  words_sent      = 0;
  int  starts_sent     = 0;
  int  results_checked = 0;
  int  settings_used   = 0;
  // Set for whole runs of words: both sides then go without idle cycles.
  logic no_idle = 1'b0;

  // Directed table. Covers the reset state, every function, both counter
  // extremes, both period extremes, all three directions, a tick while idle,
  // a step count past its bound, a volume step leaving the range on either
  // side, a skipped tick on a non-multiple, a negative tick count and wrap.
  fade_row_t dir_rows [25] = '{
    // tick straight after reset: all zero, idle
    '{ 0,      0, FUNC_TICK,       0,      0,   0,   0, TYPED,   0,   0, 1'b0},
    // start with extreme counters; direction zero holds the volume
    '{ 0,      0, FUNC_START,  32767, -32768, 127,   0, TYPED, 127,   0, 1'b1},
    '{ 0,      0, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    // tick count reaches zero and ends the fade, then a tick while idle
    '{ 0,      0, FUNC_START,      1,      5,  10,  20, TYPED,  10,  20, 1'b1},
    '{ 0,      0, FUNC_TICK,       0,      0,   0,   0, TYPED,  10,  20, 1'b0},
    '{ 0,      0, FUNC_TICK,       0,      0,   0,   0, TYPED,  10,  20, 1'b0},
    // fade down by one per tick until the step count runs out
    '{ 1,     -1, FUNC_START,    100,      2,   5,   9, TYPED,   5,   9, 1'b1},
    '{ 1,     -1, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    '{ 1,     -1, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    // step below zero volume pins both channels to zero
    '{ 1,     -4, FUNC_START,    100,    100,   2,  50, TYPED,   2,  50, 1'b1},
    '{ 1,     -4, FUNC_TICK,       0,      0,   0,   0, TYPED,   0,   0, 1'b0},
    // step count goes negative while fading down
    '{ 1,     -1, FUNC_START,     -1,      0,  64,  64, TYPED,  64,  64, 1'b1},
    '{ 1,     -1, FUNC_TICK,       0,      0,   0,   0, TYPED,   0,   0, 1'b0},
    // most negative period fading up overshoots and pins to full scale
    '{-1, -32768, FUNC_START,      5, -32768,   0,   0, TYPED,   0,   0, 1'b1},
    '{-1, -32768, FUNC_TICK,       0,      0,   0,   0, TYPED, 127, 127, 1'b0},
    // positive period: step only on multiples, right channel hits the top
    '{-1,      3, FUNC_START,      7,    -10,  10, 126, TYPED,  10, 126, 1'b1},
    '{-1,      3, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    '{-1,      3, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    '{-1,      3, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    '{-1,      3, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    // negative tick count uses its magnitude; step count wraps upward
    '{ 1,      3, FUNC_START,     -5, -32768, 127, 127, TYPED, 127, 127, 1'b1},
    '{ 1,      3, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    // largest period; tick count wraps from its most negative value
    '{ 1,  32767, FUNC_START, -32768,      3, 100, 100, TYPED, 100, 100, 1'b1},
    '{ 1,  32767, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0},
    '{ 1,  32767, FUNC_TICK,       0,      0,   0,   0, PRED,    0,   0, 1'b0}
  };

  // Pin both volumes to a bound and mark the fade as ending.
  function automatic void pin_levels(input int bound, inout logic ends);
    vol_left  = bound;
    vol_right = bound;
    ends      = 1'b1;
  endfunction

  // Advance the fade by one tick.
  function automatic void fade_tick();
    int   p;
    int   mag;
    logic ends;
    p          = period_setting;
    ends       = 1'b0;
    tick_count = tick_count - 16'sd1;
    if (p > 0) begin
      mag = (tick_count < 0) ? -int'(tick_count) : int'(tick_count);
      // off-multiple tick: no step and no end checks
      if (mag % p != 0)
        return;
      if (dir_setting > 0) begin
        step_count = step_count - 16'sd1;
        if (step_count < 0)
          pin_levels(LEVEL_MIN, ends);
        else if (vol_left != 0 && vol_right != 0) begin
          vol_left  = vol_left - 1;
          vol_right = vol_right - 1;
        end else
          pin_levels(LEVEL_MIN, ends);
      end else if (dir_setting < 0) begin
        step_count = step_count + 16'sd1;
        if (step_count > 0)
          pin_levels(LEVEL_MAX, ends);
        else if (vol_left + 1 <= LEVEL_MAX && vol_right + 1 <= LEVEL_MAX) begin
          vol_left  = vol_left + 1;
          vol_right = vol_right + 1;
        end else
          pin_levels(LEVEL_MAX, ends);
      end
    end else begin
      // period of zero or less: move by minus the period every tick
      if (dir_setting > 0) begin
        step_count = step_count + p;
        if (step_count < 0)
          pin_levels(LEVEL_MIN, ends);
        else if (vol_left >= -p && vol_right >= -p) begin
          vol_left  = vol_left + p;
          vol_right = vol_right + p;
        end else
          pin_levels(LEVEL_MIN, ends);
      end else if (dir_setting < 0) begin
        step_count = step_count - p;
        if (step_count > 0)
          pin_levels(LEVEL_MAX, ends);
        else if (vol_left - p <= LEVEL_MAX && vol_right - p <= LEVEL_MAX) begin
          vol_left  = vol_left - p;
          vol_right = vol_right - p;
        end else
          pin_levels(LEVEL_MAX, ends);
      end
    end
    if (ends || tick_count == 0 || step_count == 0)
      ramp_active = 1'b0;
  endfunction

  // Apply one accepted input word to the predictor and return its result.
  function automatic vol_word_t fade_predict(input logic func, input logic [47:0] data);
    vol_word_t res;
    if (func == FUNC_START) begin
      tick_count  = data[15:0];
      step_count  = data[31:16];
      vol_left    = int'(data[38:32]);
      vol_right   = int'(data[45:39]);
      ramp_active = 1'b1;
    end else if (ramp_active)
      fade_tick();
    res.left   = vol_left[6:0];
    res.right  = vol_right[6:0];
    res.fading = ramp_active;
    return res;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result.
  // Called and returning at a falling edge; valid stays high on return so
  // a back-to-back word does not drop it.
  task automatic send_word(input logic func, input logic [47:0] data,
                           input logic typed, input vol_word_t given);
    int        gap;
    vol_word_t predicted;
    gap           = no_idle ? 0 : $urandom_range(0, 3);
    s_axis_tvalid = (gap == 0);
    s_axis_tuser  = func;
    s_axis_tdata  = data;
    repeat (gap) @(negedge clk);
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predicted = fade_predict(func, data);
    fade_expect_q.push_back(typed ? given : predicted);
    words_sent++;
    if (func == FUNC_START)
      starts_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (fade_expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers on consecutive cycles; only while idle.
  task automatic set_fade_config(input int dir, input int period);
    cfg_we    = 1'b1;
    cfg_index = CFG_DIRECTION;
    cfg_data  = 16'(dir);
    @(negedge clk);
    cfg_index = CFG_PERIOD;
    cfg_data  = 16'(period);
    @(negedge clk);
    cfg_we         = 1'b0;
    dir_setting    = 2'(dir);
    period_setting = 16'(period);
    settings_used++;
  endtask

  // Random words under the current setting: mostly a start followed by a
  // run of ticks, with some stray words of either function mixed in.
  task automatic run_random_phase(input int n_words);
    int          sent;
    int          run_len;
    logic [15:0] ticks;
    logic [15:0] steps;
    logic [6:0]  lvl_l;
    logic [6:0]  lvl_r;
    logic [47:0] data;
    sent = 0;
    while (sent < n_words) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) begin
        data        = 48'({$urandom, $urandom});
        data[47:46] = 2'b00;
        send_word(logic'($urandom_range(0, 1)), data, PRED, '0);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0:       ticks = 16'($urandom);
          1:       ticks = 16'(-int'($urandom_range(1, 40)));
          default: ticks = 16'($urandom_range(1, 60));
        endcase
        if ($urandom_range(0, 3) == 0)
          steps = 16'($urandom);
        else begin
          steps = 16'($urandom_range(0, 40));
          if (dir_setting < 0)
            steps = -steps;
        end
        lvl_l = 7'($urandom_range(0, 127));
        lvl_r = 7'($urandom_range(0, 127));
        send_word(FUNC_START, {2'b00, lvl_r, lvl_l, steps, ticks}, PRED, '0);
        run_len = $urandom_range(0, 24);
        // tick words carry random payload; the block must ignore it
        repeat (run_len) begin
          data        = 48'({$urandom, $urandom});
          data[47:46] = 2'b00;
          send_word(FUNC_TICK, data, PRED, '0);
        end
        sent += run_len + 1;
      end
    end
  endtask

  // Stimulus: reset, directed table, then random phases.
  initial begin
    fade_row_t row;
    vol_word_t typed_val;
    int        dir;
    int        per;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_DIRECTION;
    cfg_data       = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = FUNC_TICK;
    s_axis_tdata   = '0;
    tick_count     = '0;
    step_count     = '0;
    vol_left       = 0;
    vol_right      = 0;
    ramp_active    = 1'b0;
    dir_setting    = '0;
    period_setting = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the table; rewrite the registers only when a row asks for a
    // different setting, and only once the block has gone quiet.
    for (int i = 0; i < $size(dir_rows); i++) begin
      row = dir_rows[i];
      if (row.dir != int'(dir_setting) || row.period != int'(period_setting)) begin
        settle();
        set_fade_config(row.dir, row.period);
      end
      typed_val.left   = 7'(row.exp_left);
      typed_val.right  = 7'(row.exp_right);
      typed_val.fading = row.exp_fading;
      send_word(row.func,
                {2'b00, 7'(row.right), 7'(row.left), 16'(row.steps), 16'(row.ticks)},
                row.typed, typed_val);
    end

    // Random phases, each under a fresh setting drawn with a bias toward
    // small periods, zero and the extremes.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      dir = int'($urandom_range(0, 2)) - 1;
      case ($urandom_range(0, 7))
        0:       per = $urandom_range(1, 4);
        1:       per = $urandom_range(5, 16);
        2:       per = 0;
        3:       per = -1;
        4:       per = -int'($urandom_range(2, 12));
        5:       per = $urandom_range(0, 1) ? 32767 : -32768;
        6:       per = int'($urandom_range(0, 65535)) - 32768;
        default: per = 1;
      endcase
      settle();
      set_fade_config(dir, per);
      run_random_phase(PHASE_WORDS);
    end

    // Drain, then give the block time to show any stray word.
    no_idle = 1'b0;
    settle();
    repeat (30) @(negedge clk);

    $display("Sent %0d input words (%0d fade starts) under %0d register settings.",
             words_sent, starts_sent, settings_used);
    $display("Checked %0d result words, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0 && fade_expect_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Result side: stall at random, check each accepted word in order.
  initial begin
    int        stall;
    vol_word_t want;
    m_axis_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall         = no_idle ? 0 : $urandom_range(0, 3);
      m_axis_tready = (stall == 0);
      repeat (stall) @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_checked++;
      if (fade_expect_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", m_axis_tdata);
        fail_count++;
      end else begin
        want = fade_expect_q.pop_front();
        if (m_axis_tdata[6:0] !== want.left) begin
          $error("left_volume: expected %0d, got %0d", want.left, m_axis_tdata[6:0]);
          fail_count++;
        end
        if (m_axis_tdata[13:7] !== want.right) begin
          $error("right_volume: expected %0d, got %0d", want.right, m_axis_tdata[13:7]);
          fail_count++;
        end
        if (m_axis_tdata[14] !== want.fading) begin
          $error("fading: expected %0d, got %0d", want.fading, m_axis_tdata[14]);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #3000000;
    $display("Timeout with %0d results still expected", fade_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
